@@ design/lcfc_pkg.sv @@
// shared types and constants for the length and checksum frame checker
package lcfc_pkg;

    // datagram bytes kept per frame, later bytes are dropped
    localparam int MAX_PACKET  = 1024;
    localparam int CNT_W       = $clog2(MAX_PACKET + 1);
    localparam int LEN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int HDR_BYTES   = 4;
    localparam int CMP_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    // output queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // configuration register index
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_LIMIT = 1'b0,
        CFG_BIG_ENDIAN   = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_LEN_BEYOND  = 3'd2,
        ST_OVER_BUFFER = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    // one result transaction
    typedef struct packed {
        logic              last;
        logic [LEN_W-1:0]  length;
        t_status           status;
        logic [BYTE_W-1:0] data_byte;
        t_kind             kind;
    } t_result;

    // push control into the output queue, second slot only with the first
    typedef struct packed {
        logic v0;
        logic v1;
    } t_push;

endpackage

@@ design/lcfc_out_fifo.sv @@
// four-entry result queue with up to two writes and one read per cycle
module lcfc_out_fifo
    import lcfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_data0,
    input  t_result i_data1,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic                   pop;

    // status toward both sides
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid & i_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.v0) + FIFO_PTR_W'(i_push.v1);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + FIFO_CNT_W'(i_push.v0) + FIFO_CNT_W'(i_push.v1)
                   - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_data1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue fill count beyond depth");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second slot written without the first");

    a_double_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("two results written without room for two");

endmodule

@@ design/length_checksum_frame_checker.sv @@
// length and checksum frame checker, top level
// results are registered in the result queue before they reach the master side
// one byte per cycle when not held off; a closing payload byte gives two results
// the four-entry result queue holds off the slave side when fewer than two slots are free
// reset (synchronous, active low) clears frame state and queue, buffer_limit to 65535,
// byte order to little endian
module length_checksum_frame_checker
    import lcfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // datagram bytes in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] byte_in
    input  logic                  s_axis_tlast,   // end_of_datagram
    // results out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                                  // [26:11] payload_length, [31:27] zero
    output logic                  m_axis_tuser,   // item_kind
    output logic                  m_axis_tlast    // last
);

    logic [LEN_W-1:0]  r_buffer_limit;
    logic              r_big_endian;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [LEN_W-1:0]  r_length_word, n_length_word;
    logic [LEN_W-1:0]  r_checksum_word, n_checksum_word;
    logic [LEN_W-1:0]  r_running_sum, n_running_sum;
    logic              r_over_limit, n_over_limit;

    logic              s_acc;
    logic              room2;
    logic              hdr_high;
    logic              pass;
    logic [CNT_W-1:0]  pay_idx;
    t_status           status;
    logic [LEN_W-1:0]  plen;
    t_result           res_payload, res_status, q_data;
    t_push             push;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room2;
    assign s_acc         = s_axis_tvalid & s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= '1;
            r_big_endian   <= 1'b0;
        end else if (i_cfg_valid & o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BUFFER_LIMIT: r_buffer_limit <= i_cfg_data[LEN_W-1:0];
                CFG_BIG_ENDIAN:   r_big_endian   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // header capture, payload sum and end-of-frame status
    always_comb begin
        n_byte_count    = r_byte_count;
        n_length_word   = r_length_word;
        n_checksum_word = r_checksum_word;
        n_running_sum   = r_running_sum;
        n_over_limit    = r_over_limit;
        pass            = 1'b0;
        status          = ST_OK;
        plen            = '0;
        // second byte of each header word is at odd positions
        hdr_high        = r_big_endian ? ~r_byte_count[0] : r_byte_count[0];
        pay_idx         = r_byte_count - CNT_W'(HDR_BYTES);

        if (s_acc) begin
            if (r_byte_count < CNT_W'(MAX_PACKET)) begin
                if (r_byte_count < CNT_W'(2)) begin
                    if (hdr_high) begin
                        n_length_word[15:8] = s_axis_tdata;
                    end else begin
                        n_length_word[7:0] = s_axis_tdata;
                    end
                    if (r_byte_count == CNT_W'(1)) begin
                        n_over_limit = (n_length_word > r_buffer_limit);
                    end
                end else if (r_byte_count < CNT_W'(HDR_BYTES)) begin
                    if (hdr_high) begin
                        n_checksum_word[15:8] = s_axis_tdata;
                    end else begin
                        n_checksum_word[7:0] = s_axis_tdata;
                    end
                end else if ((CMP_W'(pay_idx) < CMP_W'(r_length_word)) && !r_over_limit) begin
                    pass          = 1'b1;
                    n_running_sum = r_running_sum + LEN_W'(s_axis_tdata);
                end
                n_byte_count = r_byte_count + CNT_W'(1);
            end

            if (s_axis_tlast) begin
                if (n_byte_count < CNT_W'(HDR_BYTES)) begin
                    status = ST_TOO_SHORT;
                end else if (CMP_W'(n_length_word) >
                             (CMP_W'(n_byte_count) - CMP_W'(HDR_BYTES))) begin
                    status = ST_LEN_BEYOND;
                end else if (n_over_limit) begin
                    status = ST_OVER_BUFFER;
                end else if (n_running_sum != n_checksum_word) begin
                    status = ST_BAD_CHECKSUM;
                end else begin
                    status = ST_OK;
                    plen   = n_length_word;
                end
                // frame closed
                n_byte_count    = '0;
                n_length_word   = '0;
                n_checksum_word = '0;
                n_running_sum   = '0;
                n_over_limit    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_length_word   <= '0;
            r_checksum_word <= '0;
            r_running_sum   <= '0;
            r_over_limit    <= 1'b0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_length_word   <= n_length_word;
            r_checksum_word <= n_checksum_word;
            r_running_sum   <= n_running_sum;
            r_over_limit    <= n_over_limit;
        end
    end

    // result transactions, payload before status
    always_comb begin
        res_payload.last      = 1'b0;
        res_payload.length    = '0;
        res_payload.status    = ST_OK;
        res_payload.data_byte = s_axis_tdata;
        res_payload.kind      = KIND_PAYLOAD;

        res_status.last       = 1'b1;
        res_status.length     = plen;
        res_status.status     = status;
        res_status.data_byte  = '0;
        res_status.kind       = KIND_STATUS;

        push.v0 = s_acc & (pass | s_axis_tlast);
        push.v1 = s_acc & pass & s_axis_tlast;
    end

    lcfc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (pass ? res_payload : res_status),
        .i_data1 (res_status),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready)
    );

    // master side packing
    assign m_axis_tdata = {5'b0, q_data.length, q_data.status, q_data.data_byte};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_PACKET))
        else $error("byte count beyond packet limit");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tlast) |=> (r_byte_count == '0) && (r_running_sum == '0))
        else $error("frame state not cleared after final byte");

    a_over_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over_limit |-> (r_byte_count >= CNT_W'(2)))
        else $error("over-limit flag set before length word complete");

    a_sum_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count <= CNT_W'(HDR_BYTES)) |-> (r_running_sum == '0))
        else $error("payload summed during header");

endmodule

@@ test/tb_length_checksum_frame_checker.sv @@
// self-checking testbench for the length and checksum frame checker
`timescale 1ns / 100ps

import lcfc_pkg::*;

// expected result store with its own copy of the frame checker state
class frame_scoreboard;
    t_result             expected_q[$];
    int                  errors;
    logic [LEN_W-1:0]    buffer_limit;
    logic                big_endian;
    logic [CNT_W-1:0]    byte_count;
    logic [LEN_W-1:0]    length_word;
    logic [LEN_W-1:0]    checksum_word;
    logic [LEN_W-1:0]    running_sum;
    logic                over_limit;

    function new();
        errors       = 0;
        buffer_limit = 16'hFFFF;
        big_endian   = 1'b0;
        clear_frame();
    endfunction

    function void clear_frame();
        byte_count    = '0;
        length_word   = '0;
        checksum_word = '0;
        running_sum   = '0;
        over_limit    = 1'b0;
    endfunction

    function void apply_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_BUFFER_LIMIT: buffer_limit = value;
            CFG_BIG_ENDIAN:   big_endian   = value[0];
            default: ;
        endcase
    endfunction

    // second is 0 for the first header byte of a word, 1 for the next one
    function logic [LEN_W-1:0] merge_header_byte(logic [LEN_W-1:0] word, logic second,
                                                 logic [BYTE_W-1:0] b);
        logic high;
        high = big_endian ? !second : second;
        if (high)
            return {b, word[7:0]};
        return {word[15:8], b};
    endfunction

    // accepted input transaction, queue the results it causes
    function void note_byte(logic [BYTE_W-1:0] b, logic eod);
        t_result r;
        int      idx;
        if (int'(byte_count) < MAX_PACKET) begin
            idx = int'(byte_count);
            if (idx < 2) begin
                length_word = merge_header_byte(length_word, idx == 1, b);
                if (idx == 1)
                    over_limit = (length_word > buffer_limit);
            end else if (idx < HDR_BYTES) begin
                checksum_word = merge_header_byte(checksum_word, idx == 3, b);
            end else if ((idx - HDR_BYTES) < int'(length_word) && !over_limit) begin
                running_sum    = running_sum + b;
                r              = '0;
                r.kind         = KIND_PAYLOAD;
                r.status       = ST_OK;
                r.data_byte    = b;
                expected_q.push_back(r);
            end
            byte_count = byte_count + 1'b1;
        end
        // closing status, in priority order
        if (eod) begin
            r      = '0;
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            if (int'(byte_count) < HDR_BYTES)
                r.status = ST_TOO_SHORT;
            else if (int'(length_word) > int'(byte_count) - HDR_BYTES)
                r.status = ST_LEN_BEYOND;
            else if (over_limit)
                r.status = ST_OVER_BUFFER;
            else if (running_sum != checksum_word)
                r.status = ST_BAD_CHECKSUM;
            else begin
                r.status = ST_OK;
                r.length = length_word;
            end
            expected_q.push_back(r);
            clear_frame();
        end
    endfunction

    task report_mismatch(string msg);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // accepted output transaction against the oldest expectation
    task check_result(logic [31:0] tdata, logic tuser, logic tlast);
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, tdata %h user %b last %b",
                                      tdata, tuser, tlast));
            return;
        end
        want = expected_q.pop_front();
        if (tuser !== want.kind)
            report_mismatch($sformatf("kind %b, want %b", tuser, want.kind));
        if (tdata[7:0] !== want.data_byte)
            report_mismatch($sformatf("payload byte %h, want %h", tdata[7:0], want.data_byte));
        if (tdata[10:8] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", tdata[10:8], want.status));
        if (tdata[26:11] !== want.length)
            report_mismatch($sformatf("length %0d, want %0d", tdata[26:11], want.length));
        if (tdata[31:27] !== 5'd0)
            report_mismatch($sformatf("pad bits %b, want zero", tdata[31:27]));
        if (tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", tlast, want.last));
    endtask

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_length_checksum_frame_checker;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PATTERN,
        READY_SPARSE
    } t_ready_mode;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE       = 8;
    localparam int PHASE_BYTES  = 120;
    localparam int PHASES       = 8;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_BUFFER_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    frame_scoreboard sb = new();
    t_ready_mode     ready_mode = READY_MOSTLY;
    int              ready_cycle = 0;
    int              idle_cycles = 0;
    int              burst_left  = 0;
    bit              idle_enable = 1'b1;
    logic [7:0]      frame_q[$];

    length_checksum_frame_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        case (ready_mode)
            READY_ALWAYS:  m_axis_tready <= 1'b1;
            READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: m_axis_tready <= ((ready_cycle % 13) < 7) ^ (ready_cycle[5]);
            default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // transaction monitor on all three channels, with the idle counter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (i_cfg_valid && o_cfg_ready)
                sb.apply_register(t_cfg_index'(i_cfg_index), i_cfg_data);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("length_checksum_frame_checker regression: fail");
        $finish;
    end

    task write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one byte transaction, in bursts of random length with random gaps while idle_enable is set
    task send_byte(logic [7:0] b, logic eod);
        int gap;
        if (burst_left == 0) begin
            gap = idle_enable ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = idle_enable ? $urandom_range(1, 24) : 100000;
        end
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task send_frame();
        int k;
        for (k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == frame_q.size() - 1);
    endtask

    task stop_stream();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // first waits on the clock so the monitor has seen the last accepted byte
    task wait_for_results(int settle);
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // header plus body; swap_order writes the header words in the other byte order
    function void build_frame(int hdr_len, int body_len, bit csum_good, bit swap_order);
        logic [15:0] len16;
        logic [15:0] sum;
        logic [15:0] csum;
        logic [7:0]  b;
        logic        order;
        int          k;
        frame_q.delete();
        len16 = hdr_len[15:0];
        sum   = '0;
        order = sb.big_endian ^ swap_order;
        repeat (HDR_BYTES) frame_q.push_back(8'h00);
        for (k = 0; k < body_len; k++) begin
            b = 8'($urandom);
            if (k < hdr_len && k < MAX_PACKET - HDR_BYTES)
                sum = sum + b;
            frame_q.push_back(b);
        end
        csum = csum_good ? sum : sum ^ (16'h1 << $urandom_range(0, 15));
        frame_q[0] = order ? len16[15:8] : len16[7:0];
        frame_q[1] = order ? len16[7:0]  : len16[15:8];
        frame_q[2] = order ? csum[15:8]  : csum[7:0];
        frame_q[3] = order ? csum[7:0]   : csum[15:8];
    endfunction

    // mostly well-formed frames, the rest short, truncated in length or broken
    function void make_random_frame();
        int sel;
        int len;
        int body;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            frame_q.delete();
            n = $urandom_range(1, 3);
            repeat (n) frame_q.push_back(8'($urandom));
            return;
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        if (sel < 18) begin
            // header length beyond the bytes that follow
            len  = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
            body = $urandom_range(0, (len - 1 < 40) ? len - 1 : 40);
            build_frame(len, body, 1'b1, 1'b0);
        end else if (sel < 28) begin
            build_frame(len, len, 1'b0, 1'b0);
        end else if (sel < 34) begin
            build_frame(len, $urandom_range(0, 40), 1'($urandom_range(0, 1)), 1'b1);
        end else if (sel < 50) begin
            // trailing bytes past the payload
            build_frame(len, len + $urandom_range(1, 6), 1'b1, 1'b0);
        end else begin
            build_frame(len, len, 1'b1, 1'b0);
        end
    endfunction

    // stimulus
    initial begin
        int          phase;
        int          sent;
        logic [15:0] limit;
        logic        order;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at reset settings: little endian, no buffer limit
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h00, 8'hFF, 8'h80};
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        // closing byte is also payload: payload result then status
        frame_q = '{8'h02, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        send_frame();
        frame_q = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02};
        send_frame();
        // bad checksum and one ignored byte past the payload
        frame_q = '{8'h01, 8'h00, 8'h12, 8'h34, 8'h56, 8'hAA};
        send_frame();
        stop_stream();

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_results(SETTLE);
            idle_enable = 1'b1;
            case (phase)
                0: begin limit = 16'hFFFF; order = 1'b0; ready_mode <= READY_ALWAYS;
                         idle_enable = 1'b0; end
                1: begin limit = 16'h0000; order = 1'b1; ready_mode <= READY_MOSTLY; end
                2: begin limit = 16'hFFFF; order = 1'b1; ready_mode <= READY_PATTERN; end
                3: begin limit = 16'd20;   order = 1'b0; ready_mode <= READY_SPARSE; end
                4: begin limit = 16'($urandom_range(0, 64)); order = 1'($urandom_range(0, 1));
                         ready_mode <= t_ready_mode'($urandom_range(0, 3)); end
                5: begin limit = 16'd1;    order = 1'b0; ready_mode <= READY_MOSTLY; end
                6: begin limit = 16'h8000; order = 1'b1; ready_mode <= READY_SPARSE; end
                default: begin limit = 16'd1020; order = 1'b0;
                         ready_mode <= READY_PATTERN; end
            endcase
            write_register(CFG_BUFFER_LIMIT, limit);
            write_register(CFG_BIG_ENDIAN, {15'd0, order});

            // datagram longer than the kept bytes
            if (phase == 2) begin
                build_frame(1020, 1026, 1'b1, 1'b0);
                send_frame();
            end

            sent = 0;
            while (sent < PHASE_BYTES) begin
                make_random_frame();
                sent += frame_q.size();
                send_frame();
            end
            stop_stream();
        end

        wait_for_results(SETTLE + 2);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("length_checksum_frame_checker regression: pass");
        else
            $display("length_checksum_frame_checker regression: fail");
        $finish;
    end

endmodule
